// ===== rtl/cdq_pkg.sv =====
// Shared constants, codes and types for the circular deque.
`timescale 1ns / 1ps
`default_nettype none
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int CAP_W         = 5;
   localparam int MODE_W        = 3;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_IDX_W     = CSR_ADDR_W - 2;

   localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(16);
   localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE       = 3'd0,
      MODE_PUSH_FRONT = 3'd1,
      MODE_PUSH_BACK  = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_POP_BACK   = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAPACITY = 2'd0
   } reg_index_type;

   typedef struct packed {
      logic exec;
      logic rd_en;
   } cdq_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/cdq_req_if.sv =====
// Request channel: operation and value, valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface cdq_req_if;
   import cdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [DATA_W-1:0] data_in;

   modport source (output valid, output mode, output data_in, input ready);
   modport sink (input valid, input mode, input data_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/cdq_rsp_if.sv =====
// Response channel: status word of the deque after each operation.
`timescale 1ns / 1ps
`default_nettype none
interface cdq_rsp_if;
   import cdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     success;
   logic signed [DATA_W-1:0] front_value;
   logic signed [DATA_W-1:0] rear_value;
   logic                     is_empty;
   logic                     is_full;
   logic [CAP_W-1:0]         item_count;

   modport source (output valid, output success, output front_value, output rear_value,
                   output is_empty, output is_full, output item_count, input ready);
   modport sink (input valid, input success, input front_value, input rear_value,
                 input is_empty, input is_full, input item_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
// Sequencing state machine: accept, read ring slots, present response.
`timescale 1ns / 1ps
`default_nettype none
module cdq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output cdq_pkg::cdq_cmd_type      cmd
);
   import cdq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/cdq_dp.sv =====
// Datapath: ring store, end pointers, count, capacity register, result words.
`timescale 1ns / 1ps
`default_nettype none
module cdq_dp #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cdq_pkg::cdq_cmd_type          cmd,
   input  wire logic [cdq_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [cdq_pkg::DATA_W-1:0]    req_data_in,
   input  wire logic                          cfg_wr,
   input  wire logic [cdq_pkg::CAP_W-1:0]     cfg_data,
   output logic [cdq_pkg::CAP_W-1:0]          cap_value,
   output logic                               rsp_success,
   output logic [cdq_pkg::DATA_W-1:0]         rsp_front_value,
   output logic [cdq_pkg::DATA_W-1:0]         rsp_rear_value,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   output logic [cdq_pkg::CAP_W-1:0]          rsp_item_count
);
   import cdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic [DATA_W-1:0] ring_mem [DEPTH];

   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  rear_ff, rear_in;
   logic [CAP_W-1:0]  count_ff, count_in;
   logic              success_ff, success_in;
   logic [DATA_W-1:0] front_q_ff;
   logic [DATA_W-1:0] rear_q_ff;

   logic [CAP_W-1:0]  cap_eff;
   logic              empty_now;
   logic              full_now;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;

   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
                                                input logic [CAP_W-1:0] c);
      logic [31:0] nxt;
      nxt = 32'(i) + 32'd1;
      return (nxt >= 32'(c)) ? '0 : IDX_W'(nxt);
   endfunction

   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
                                                  input logic [CAP_W-1:0] c);
      logic [CAP_W-1:0] top;
      top = c - CAP_W'(1);
      return (i == '0 || 32'(i) >= 32'(c)) ? IDX_W'(top) : i - IDX_W'(1);
   endfunction

   always_comb begin
      cap_eff = cap_ff;
      if (cap_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (32'(cap_ff) > 32'(DEPTH)) begin
         cap_eff = CAP_W'(DEPTH);
      end
   end

   assign empty_now = (count_ff == '0);
   assign full_now  = (count_ff >= cap_eff);

   always_comb begin
      cap_in     = cap_ff;
      front_in   = front_ff;
      rear_in    = rear_ff;
      count_in   = count_ff;
      success_in = success_ff;
      wr_en      = 1'b0;
      wr_addr    = front_ff;
      if (cmd.exec) begin
         success_in = 1'b1;
         case (req_mode) inside
            MODE_NONE: begin
            end
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
               if (full_now) begin
                  success_in = 1'b0;
               end else begin
                  count_in = count_ff + CAP_W'(1);
                  wr_en    = 1'b1;
                  if (empty_now) begin
                     front_in = '0;
                     rear_in  = '0;
                     wr_addr  = '0;
                  end else if (req_mode == MODE_PUSH_FRONT) begin
                     front_in = step_down(front_ff, cap_eff);
                     wr_addr  = front_in;
                  end else begin
                     rear_in = step_up(rear_ff, cap_eff);
                     wr_addr = rear_in;
                  end
               end
            end
            MODE_POP_FRONT: begin
               if (empty_now) begin
                  success_in = 1'b0;
               end else begin
                  front_in = step_up(front_ff, cap_eff);
                  count_in = count_ff - CAP_W'(1);
               end
            end
            MODE_POP_BACK: begin
               if (empty_now) begin
                  success_in = 1'b0;
               end else begin
                  rear_in  = step_down(rear_ff, cap_eff);
                  count_in = count_ff - CAP_W'(1);
               end
            end
            default: begin
               success_in = 1'b0;
            end
         endcase
      end
      if (cfg_wr) begin
         cap_in   = cfg_data;
         front_in = '0;
         rear_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CAP_RESET;
         front_ff   <= '0;
         rear_ff    <= '0;
         count_ff   <= '0;
         success_ff <= 1'b0;
      end else begin
         cap_ff     <= cap_in;
         front_ff   <= front_in;
         rear_ff    <= rear_in;
         count_ff   <= count_in;
         success_ff <= success_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= req_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         front_q_ff <= ring_mem[front_ff];
         rear_q_ff  <= ring_mem[rear_ff];
      end
   end

   assign cap_value       = cap_ff;
   assign rsp_success     = success_ff;
   assign rsp_is_empty    = empty_now;
   assign rsp_is_full     = full_now;
   assign rsp_item_count  = count_ff;
   assign rsp_front_value = empty_now ? EMPTY_VALUE : front_q_ff;
   assign rsp_rear_value  = empty_now ? EMPTY_VALUE : rear_q_ff;
endmodule
`default_nettype wire

// ===== rtl/circular_deque.sv =====
// Top level of the circular deque: channels, register port, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Double-ended queue in a ring of DEPTH 32-bit words. Each request word carries
// an operation (none, push front, push back, pop front, pop back) and a value;
// each produces one response word with the success flag, front and rear values
// (-1 when empty), empty and full flags and the count. A request is accepted,
// the ring store is read at both ends in the next cycle, and the response is
// shown in the cycle after that. No new request is accepted until the response
// has been taken. Register 0 (capacity, byte address 0) sets the ring slots in
// use; writing it empties the deque. Capacity 0 acts as 1 and values above
// DEPTH act as DEPTH.
module circular_deque #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   cdq_req_if.sink                                req_bus,
   cdq_rsp_if.source                              rsp_bus,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cdq_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [cdq_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cdq_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);
   import cdq_pkg::*;

   cdq_cmd_type       cmd;
   logic              cfg_wr;
   logic [CAP_W-1:0]  cap_value;
   logic [CSR_IDX_W-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_idx == REG_CAPACITY);

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         REG_CAPACITY: csr_prdata = CSR_DATA_W'(cap_value);
         default:      csr_prdata = '0;
      endcase
   end

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   cdq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_bus.mode),
      .req_data_in     (req_bus.data_in),
      .cfg_wr          (cfg_wr),
      .cfg_data        (csr_pwdata[CAP_W-1:0]),
      .cap_value       (cap_value),
      .rsp_success     (rsp_bus.success),
      .rsp_front_value (rsp_bus.front_value),
      .rsp_rear_value  (rsp_bus.rear_value),
      .rsp_is_empty    (rsp_bus.is_empty),
      .rsp_is_full     (rsp_bus.is_full),
      .rsp_item_count  (rsp_bus.item_count)
   );
endmodule
`default_nettype wire
